/* design/bffa_pkg.sv */
// bffa_pkg: shared types and constants for the first-fit bitmap allocator
// no dependencies; used by every module of the allocator except bffa_ram
`default_nettype none

package bffa_pkg;

    localparam int NUM_W           = 14;
    localparam int WORD_W          = 32;
    localparam int MAP_ENTRIES_DEF = 8192;
    localparam int PADDR_W         = 2;
    localparam int PDATA_W         = 32;

    localparam logic [PADDR_W-1:0] REG_ENTRIES_ADDR = '0;

    localparam logic [NUM_W-1:0] ENTRIES_RESET = 14'd8192;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [NUM_W-1:0] entry_number;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0] allocated_number;
        t_status          status;
        logic [NUM_W-1:0] free_count;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic    clear;
        logic    load;
        logic    read;
        logic    finish;
        t_status code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic dvalid;
        logic found;
        logic eval_last;
        logic bit_used;
        logic range_bad;
        logic lim_zero;
        logic is_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/bffa_ram.sv */
// bffa_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/bffa_ctrl.sv */
// bffa_ctrl: sequencer for clear pass, word scan and free update
// depends on bffa_pkg (t_cmd, t_sts, t_status)
`default_nettype none

module bffa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire bffa_pkg::t_sts i_sts,
    output bffa_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    logic           out_free;
    bffa_pkg::t_cmd cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (out_free) begin
                    if (!i_sts.is_free) begin
                        if (i_sts.lim_zero) begin
                            cmd.finish = 1'b1;
                            cmd.code   = bffa_pkg::ST_FULL;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_sts.range_bad) begin
                        cmd.finish = 1'b1;
                        cmd.code   = bffa_pkg::ST_RANGE;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    cmd.read = 1'b1;
                    if (i_sts.dvalid && i_sts.found) begin
                        cmd.finish = 1'b1;
                        cmd.code   = bffa_pkg::ST_OK;
                        n_state    = S_IDLE;
                    end else if (i_sts.dvalid && i_sts.eval_last) begin
                        cmd.finish = 1'b1;
                        cmd.code   = bffa_pkg::ST_FULL;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_FREE_RD: begin
                cmd.read = 1'b1;
                n_state  = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (out_free && i_sts.dvalid) begin
                    cmd.finish = 1'b1;
                    cmd.code   = i_sts.bit_used ? bffa_pkg::ST_OK
                                                : bffa_pkg::ST_ALREADY_FREE;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/bffa_dp.sv */
// bffa_dp: bitmap memory, scan address, first-free search, counters and result register
// depends on bffa_pkg and bffa_ram
`default_nettype none

module bffa_dp #(
    parameter int MAP_ENTRIES = bffa_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bffa_pkg::t_in                 i_in_data,
    output bffa_pkg::t_out                     o_out_data,
    input  wire bffa_pkg::t_cmd                i_cmd,
    output bffa_pkg::t_sts                     o_sts,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bffa_pkg::PDATA_W-1:0]  pwdata,
    output logic      [bffa_pkg::PDATA_W-1:0]  prdata
);

    localparam int NW     = bffa_pkg::NUM_W;
    localparam int WW     = bffa_pkg::WORD_W;
    localparam int WORDS  = (MAP_ENTRIES + WW - 1) / WW;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW     = $clog2(WW);
    localparam int CW     = $clog2(MAP_ENTRIES + 1);
    localparam int LW     = (CW > NW) ? CW : NW;

    logic [NW-1:0]     r_limit_cfg;
    bffa_pkg::t_op     r_op;
    logic [NW-1:0]     r_num;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_eval_addr;
    logic              r_dvalid;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     n_used;
    bffa_pkg::t_out    r_out;

    logic [LW-1:0]     cfg_ext;
    logic [LW-1:0]     lim;
    logic [LW-1:0]     lim_m1;
    logic [AW-1:0]     last_w;
    logic [BW-1:0]     last_b;
    logic [NW-1:0]     in_m1;
    logic [AW-1:0]     free_w;
    logic [NW-1:0]     num_m1;
    logic [BW-1:0]     num_b;
    logic [WW-1:0]     rdata;
    logic [WW-1:0]     mask;
    logic [WW-1:0]     free_vec;
    logic [BW-1:0]     found_pos;
    logic              found;
    logic              eval_last;
    logic [BW-1:0]     sel_bit;
    logic [WW-1:0]     onehot;
    logic              commit_ok;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic [NW-1:0]     got;
    logic [LW-1:0]     used_ext;
    logic [NW-1:0]     free_cnt;

    // active limit and its last word
    assign cfg_ext = LW'(r_limit_cfg);
    assign lim     = (cfg_ext > LW'(MAP_ENTRIES)) ? LW'(MAP_ENTRIES) : cfg_ext;
    assign lim_m1  = lim - LW'(1);
    assign last_w  = AW'(lim_m1 >> BW);
    assign last_b  = lim_m1[BW-1:0];

    assign in_m1   = i_in_data.entry_number - NW'(1);
    assign free_w  = AW'(in_m1 >> BW);
    assign num_m1  = r_num - NW'(1);
    assign num_b   = num_m1[BW-1:0];

    // first free bit in the word under test
    assign eval_last = (r_eval_addr == last_w);
    assign mask      = eval_last ? ({WW{1'b1}} >> (BW'(WW - 1) - last_b)) : {WW{1'b1}};
    assign free_vec  = ~rdata & mask;
    assign found     = |free_vec;

    always_comb begin
        found_pos = '0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (free_vec[j]) begin
                found_pos = BW'(j);
            end
        end
    end

    assign sel_bit   = (r_op == bffa_pkg::OP_FREE) ? num_b : found_pos;
    assign onehot    = WW'(1) << sel_bit;
    assign commit_ok = i_cmd.finish && (i_cmd.code == bffa_pkg::ST_OK);

    assign ram_we    = i_cmd.clear || commit_ok;
    assign ram_waddr = i_cmd.clear ? r_addr : r_eval_addr;
    assign ram_wdata = i_cmd.clear ? '0
                     : (r_op == bffa_pkg::OP_FREE) ? (rdata & ~onehot) : (rdata | onehot);

    bffa_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_used = r_used;
        if (commit_ok) begin
            if (r_op == bffa_pkg::OP_ALLOC) begin
                n_used = r_used + CW'(1);
            end else if (r_used != '0) begin
                n_used = r_used - CW'(1);
            end
        end
    end

    assign used_ext = LW'(n_used);
    assign free_cnt = (lim > used_ext) ? NW'(lim - used_ext) : '0;
    assign got      = NW'({r_eval_addr, found_pos}) + NW'(1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_cfg <= bffa_pkg::ENTRIES_RESET;
            r_addr      <= '0;
            r_dvalid    <= 1'b0;
            r_used      <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                r_limit_cfg <= pwdata[NW-1:0];
            end
            if (i_cmd.clear) begin
                r_addr <= r_addr + AW'(1);
            end else if (i_cmd.load) begin
                r_addr <= (i_in_data.op == bffa_pkg::OP_FREE) ? free_w : '0;
            end else if (i_cmd.read) begin
                r_addr <= (r_addr == last_w) ? r_addr : r_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_dvalid <= 1'b0;
            end else if (i_cmd.read) begin
                r_dvalid <= 1'b1;
            end
            r_used <= n_used;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.op;
            r_num <= i_in_data.entry_number;
        end
        if (i_cmd.read) begin
            r_eval_addr <= r_addr;
        end
        if (i_cmd.finish) begin
            r_out.allocated_number <= (commit_ok && (r_op == bffa_pkg::OP_ALLOC)) ? got : '0;
            r_out.status           <= i_cmd.code;
            r_out.free_count       <= free_cnt;
        end
    end

    assign o_sts.clear_last = (r_addr == AW'(WORDS - 1));
    assign o_sts.dvalid     = r_dvalid;
    assign o_sts.found      = found;
    assign o_sts.eval_last  = eval_last;
    assign o_sts.bit_used   = rdata[num_b];
    assign o_sts.range_bad  = (r_num == '0) || (LW'(r_num) > lim);
    assign o_sts.lim_zero   = (lim == '0);
    assign o_sts.is_free    = (r_op == bffa_pkg::OP_FREE);

    assign o_out_data = r_out;
    assign prdata     = bffa_pkg::PDATA_W'(r_limit_cfg);

endmodule

`default_nettype wire

/* design/bitmap_first_free_allocator_core.sv */
// allocate: the result follows a scan of w 32-bit words, w at most ceil(limit/32), limit capped at MAP_ENTRIES
// free requests read a single word, rejected ones none; one request in flight, throughput set by the scan
// the scan reads one bitmap word per cycle while the result is not stalled, through the single read port of the map
// after reset a clearing pass writes ceil(MAP_ENTRIES/32) words (256 words by default)
// with o_in_stall held high; configuration writes are taken during the pass
`default_nettype none

module bitmap_first_free_allocator_core #(
    parameter int MAP_ENTRIES = bffa_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire bffa_pkg::t_in                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output bffa_pkg::t_out                     o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bffa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bffa_pkg::PDATA_W-1:0]  pwdata,
    output logic      [bffa_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    bffa_pkg::t_cmd cmd;
    bffa_pkg::t_sts sts;
    logic [bffa_pkg::PDATA_W-1:0] reg_rdata;

    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bffa_dp #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pwdata     (pwdata),
        .prdata     (reg_rdata)
    );

    // single register at byte address zero, other addresses read as zero
    assign prdata = (paddr == bffa_pkg::REG_ENTRIES_ADDR) ? reg_rdata : '0;
    assign pready = 1'b1;

endmodule

`default_nettype wire

/* design/bffa_checker.sv */
// bffa_checker: port-level assertions for the allocator, bound to the top level
// depends on bffa_pkg and bitmap_first_free_allocator_core
`default_nettype none

module bffa_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire bffa_pkg::t_out                o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // only one request in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat accepted while busy");

    // full means every entry below the limit is used
    a_full_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == bffa_pkg::ST_FULL)
        |-> (o_out_data.allocated_number == '0) && (o_out_data.free_count == '0))
        else $error("full result with free entries or a number");

    // a non-zero number comes only with a good status
    a_number_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.allocated_number != '0)
        |-> (o_out_data.status == bffa_pkg::ST_OK))
        else $error("number returned with an error status");

endmodule

bind bitmap_first_free_allocator_core bffa_checker u_bffa_checker (.*);

`default_nettype wire

/* tb/sv/tb_bitmap_first_free_allocator_core.sv */
// tb_bitmap_first_free_allocator_core: self-checking bench for the first-fit bitmap allocator,
// with directed, back-pressure and random phases checked against an in-bench bitmap predictor
// depends on bffa_pkg and bitmap_first_free_allocator_core
`default_nettype none

module tb_bitmap_first_free_allocator_core;

    localparam int MAP_SIZE    = bffa_pkg::MAP_ENTRIES_DEF;
    localparam int ITEM_TARGET = 1650;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    bffa_pkg::t_in                 i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    bffa_pkg::t_out                o_out_data;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [bffa_pkg::PADDR_W-1:0]  paddr       = '0;
    logic [bffa_pkg::PDATA_W-1:0]  pwdata      = '0;
    logic [bffa_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    bitmap_first_free_allocator_core #(
        .MAP_ENTRIES(MAP_SIZE)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    bit                         used_map [MAP_SIZE];
    int unsigned                used_total = 0;
    logic [bffa_pkg::NUM_W-1:0] limit_reg  = bffa_pkg::ENTRIES_RESET;

    bffa_pkg::t_out pending_results[$];
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   burst_left     = 0;
    int   hold_off_request = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int active_limit();
        return (limit_reg > MAP_SIZE) ? MAP_SIZE : int'(limit_reg);
    endfunction

    function automatic bffa_pkg::t_out apply_request(bffa_pkg::t_in req);
        bffa_pkg::t_out res;
        int   lim;
        int   idx;
        bit   found;
        lim = active_limit();
        found = 1'b0;
        res.allocated_number = '0;
        res.status = bffa_pkg::ST_OK;
        if (req.op == bffa_pkg::OP_ALLOC) begin
            res.status = bffa_pkg::ST_FULL;
            for (idx = 0; idx < lim && !found; idx++) begin
                if (!used_map[idx]) begin
                    used_map[idx] = 1'b1;
                    used_total++;
                    res.allocated_number = bffa_pkg::NUM_W'(idx + 1);
                    res.status = bffa_pkg::ST_OK;
                    found = 1'b1;
                end
            end
        end else if (req.entry_number == 0 || int'(req.entry_number) > lim) begin
            res.status = bffa_pkg::ST_RANGE;
        end else if (!used_map[req.entry_number - 1]) begin
            res.status = bffa_pkg::ST_ALREADY_FREE;
        end else begin
            used_map[req.entry_number - 1] = 1'b0;
            if (used_total > 0) used_total--;
        end
        res.free_count = (lim > used_total) ? bffa_pkg::NUM_W'(lim - used_total) : '0;
        return res;
    endfunction

    // random entry currently marked used below the limit, 0 if none
    function automatic logic [bffa_pkg::NUM_W-1:0] pick_used_entry();
        int lim;
        int start;
        int k;
        int idx;
        lim = active_limit();
        if (lim == 0) return '0;
        start = $urandom_range(0, lim - 1);
        for (k = 0; k < lim; k++) begin
            idx = (start + k) % lim;
            if (used_map[idx]) return bffa_pkg::NUM_W'(idx + 1);
        end
        return '0;
    endfunction

    task automatic offer_request(input bffa_pkg::t_op op,
                                 input logic [bffa_pkg::NUM_W-1:0] num);
        bffa_pkg::t_in req;
        int  gap;
        req.op = op;
        req.entry_number = num;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(apply_request(req));
        items_sent++;
    endtask

    // drop valid and wait until every beat has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic read_limit(output logic [bffa_pkg::NUM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= bffa_pkg::REG_ENTRIES_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value = prdata[bffa_pkg::NUM_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_limit(input logic [bffa_pkg::NUM_W-1:0] value);
        logic [bffa_pkg::NUM_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bffa_pkg::REG_ENTRIES_ADDR;
        pwdata  <= bffa_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        limit_reg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        psel    <= 1'b0;
        @(posedge i_clk);
        read_limit(readback);
        if (readback !== value) begin
            $error("entries_in_use readback: expected %0d, actual %0d", value, readback);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input bffa_pkg::t_out got);
        bffa_pkg::t_out want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.allocated_number !== want.allocated_number) begin
            $error("allocated_number: expected %0d, actual %0d",
                   want.allocated_number, got.allocated_number);
            mismatch_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.free_count !== want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
            mismatch_count++;
        end
    endtask

    // receiver: checks beats and runs its own stall pattern
    int stall_mode = 0;
    int mode_left  = 0;
    int mode_step  = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            check_result(o_out_data);
        if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
        end
        if (mode_left == 0) begin
            mode_left  = $urandom_range(16, 200);
            stall_mode = $urandom_range(0, 4);
        end
        mode_left--;
        mode_step++;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                3: i_out_stall <= mode_step[0];
                default: i_out_stall <= ((mode_step % 8) < 5);
            endcase
        end
    end

    task automatic test_directed();
        logic [bffa_pkg::NUM_W-1:0] reset_limit;
        read_limit(reset_limit);
        if (reset_limit !== bffa_pkg::ENTRIES_RESET) begin
            $error("entries_in_use after reset: expected %0d, actual %0d",
                   bffa_pkg::ENTRIES_RESET, reset_limit);
            mismatch_count++;
        end
        program_limit(bffa_pkg::NUM_W'(3));
        repeat (3) offer_request(bffa_pkg::OP_ALLOC, '0);
        offer_request(bffa_pkg::OP_ALLOC, '0);                   // map full
        offer_request(bffa_pkg::OP_FREE, '0);                    // number zero
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(4));   // just above limit
        offer_request(bffa_pkg::OP_FREE, '1);
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(2));
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(2));   // already free
        offer_request(bffa_pkg::OP_ALLOC, '1);
        settle();
        program_limit(bffa_pkg::NUM_W'(1));      // limit lowered under used entries
        offer_request(bffa_pkg::OP_ALLOC, '0);
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(3));
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(1));
        settle();
        program_limit('0);                       // limit zero
        offer_request(bffa_pkg::OP_ALLOC, '0);
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(1));
        settle();
        program_limit('1);                       // limit above the map
        offer_request(bffa_pkg::OP_ALLOC, '0);
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(3));
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(MAP_SIZE));
        offer_request(bffa_pkg::OP_FREE, bffa_pkg::NUM_W'(MAP_SIZE + 1));
        offer_request(bffa_pkg::OP_ALLOC, '0);
        settle();
    endtask

    task automatic random_request(input int alloc_pct);
        int lim;
        int r;
        lim = active_limit();
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            offer_request(bffa_pkg::OP_ALLOC, bffa_pkg::NUM_W'($urandom()));
        end else begin
            case ($urandom_range(0, 9))
                0: offer_request(bffa_pkg::OP_FREE,
                                 bffa_pkg::NUM_W'($urandom_range(0, 16383)));
                1: offer_request(bffa_pkg::OP_FREE,
                                 (lim == 0) ? '0 : bffa_pkg::NUM_W'($urandom_range(1, lim)));
                2: offer_request(bffa_pkg::OP_FREE,
                                 $urandom_range(0, 1) ? bffa_pkg::NUM_W'(lim + 1) : '0);
                default: offer_request(bffa_pkg::OP_FREE, pick_used_entry());
            endcase
        end
    endtask

    task automatic test_hold_off();
        program_limit(bffa_pkg::NUM_W'(24));
        hold_off_request = 400;
        repeat (30) random_request(70);
        settle();
    endtask

    task automatic test_large_map();
        program_limit(bffa_pkg::NUM_W'(MAP_SIZE));
        repeat (120) random_request(85);
        settle();
        program_limit(bffa_pkg::NUM_W'(MAP_SIZE - 1));
        repeat (30) random_request(50);
        settle();
    endtask

    task automatic test_random_phases();
        int lim_choice;
        int alloc_pct;
        int n;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 15))
                0: lim_choice = 0;
                1: lim_choice = MAP_SIZE;
                2: lim_choice = $urandom_range(MAP_SIZE + 1, 16383);
                3: lim_choice = $urandom_range(97, 600);
                default: lim_choice = $urandom_range(1, 96);
            endcase
            case ($urandom_range(0, 3))
                0: alloc_pct = 25;
                1: alloc_pct = 50;
                2: alloc_pct = 75;
                default: alloc_pct = 95;
            endcase
            program_limit(bffa_pkg::NUM_W'(lim_choice));
            n = $urandom_range(20, 120);
            repeat (n) random_request(alloc_pct);
            settle();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_hold_off();
        test_large_map();
        test_random_phases();
        settle();
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bitmap_first_free_allocator_core test passed");
        else
            $display("bitmap_first_free_allocator_core test failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("bitmap_first_free_allocator_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_ctrl.sv
design/bffa_dp.sv
design/bitmap_first_free_allocator_core.sv
design/bffa_checker.sv
tb/sv/tb_bitmap_first_free_allocator_core.sv
